// ===== sv/rcff_pkg.sv =====
`timescale 1ns / 1ps
package rcff_pkg;

  localparam int NUM_HELD   = 6;
  localparam int NUM_SMOOTH = 6;

  // request kinds
  localparam logic REQ_PACKET = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // config register indexes
  localparam logic [1:0] CFG_ALPHA   = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT = 2'd1;

  // smoothed channel order
  localparam logic [2:0] CH_THROTTLE   = 3'd0;
  localparam logic [2:0] CH_YAW        = 3'd1;
  localparam logic [2:0] CH_PITCH      = 3'd2;
  localparam logic [2:0] CH_ROLL_LEFT  = 3'd3;
  localparam logic [2:0] CH_ROLL_RIGHT = 3'd4;
  localparam logic [2:0] CH_HOLD       = 3'd5;
  localparam logic [2:0] LAST_CH       = CH_HOLD;

  // held byte order
  localparam logic [2:0] H_ROLL = 3'd3;
  localparam logic [2:0] H_HOLD = 3'd4;
  localparam logic [2:0] H_SEL  = 3'd5;

  // wing modes
  localparam logic [7:0] SEL_ROLL = 8'd0;
  localparam logic [7:0] SEL_HOLD = 8'd1;

  localparam logic [10:0] PULSE_MIN = 11'd1000;
  localparam logic [10:0] PULSE_MAX = 11'd2000;
  localparam logic [10:0] PULSE_MID = 11'd1500;

  localparam logic [8:0]  ALPHA_RESET   = 9'd154;
  localparam logic [8:0]  ALPHA_ONE     = 9'd256;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] SILENCE_MAX   = 16'hFFFF;

  // x*1000/255 == (x * 1000 * ceil(2^26/255)) >> 26 for every 8-bit x
  localparam logic [27:0] MAP_RECIP = 28'd263173000;

  typedef logic [7:0]  held_arr_t   [NUM_HELD];
  typedef logic [10:0] smooth_arr_t [NUM_SMOOTH];

  localparam held_arr_t HELD_FAILSAFE =
    '{8'd0, 8'd127, 8'd127, 8'd127, 8'd127, 8'd0};
  localparam smooth_arr_t SMOOTH_RESET =
    '{11'd1000, 11'd1000, 11'd1000, 11'd1000, 11'd2000, 11'd1000};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_EMA,
    ST_DONE
  } rcff_state_t;

  typedef struct packed {
    logic       take_packet;
    logic       take_tick;
    logic       map_en;
    logic       ema_en;
    logic       finish;
    logic [2:0] ch;
  } rcff_cmd_t;

  function automatic logic [10:0] map_pulse(input logic [7:0] x);
    logic [35:0] prod;
    prod = {28'd0, x} * {8'd0, MAP_RECIP};
    return PULSE_MIN + {1'b0, prod[35:26]};
  endfunction

endpackage

// ===== sv/rcff_ctrl.sv =====
`timescale 1ns / 1ps
module rcff_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_req_type,
  input  logic               out_ready,
  input  logic               out_busy,
  output logic               in_ready,
  output rcff_pkg::rcff_cmd_t cmd
);
  import rcff_pkg::*;

  rcff_state_t state_r, state_nxt;
  logic [2:0]  ch_r, ch_nxt;
  logic        accept;
  logic        slot_free;

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_busy || out_ready;

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_req_type == REQ_TICK) begin
          state_nxt = ST_MAP;
          ch_nxt    = CH_THROTTLE;
        end
      end
      ST_MAP: state_nxt = ST_EMA;
      ST_EMA: begin
        if (ch_r == LAST_CH) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MAP;
          ch_nxt    = ch_r + 3'd1;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.ch   = ch_r;
    case (state_r)
      ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.take_packet = accept && in_req_type == REQ_PACKET;
        cmd.take_tick   = accept && in_req_type == REQ_TICK;
      end
      ST_MAP:  cmd.map_en = 1'b1;
      ST_EMA:  cmd.ema_en = 1'b1;
      ST_DONE: cmd.finish = slot_free;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= CH_THROTTLE;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  ap_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_req_type == REQ_TICK) |=>
      (state_r == ST_MAP && ch_r == CH_THROTTLE))
    else $error("tick did not start channel sweep");

  ap_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    ch_r <= LAST_CH)
    else $error("channel index out of range");

  ap_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_busy)
    else $error("finish did not load output register");
`endif
endmodule

// ===== sv/rcff_dp.sv =====
`timescale 1ns / 1ps
module rcff_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  rcff_pkg::rcff_cmd_t cmd,
  input  logic [7:0]          in_throttle,
  input  logic [7:0]          in_yaw,
  input  logic [7:0]          in_pitch,
  input  logic [7:0]          in_roll,
  input  logic [7:0]          in_hold_level,
  input  logic [7:0]          in_aux_select,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [10:0]         out_throttle_pulse,
  output logic [10:0]         out_yaw_pulse,
  output logic [10:0]         out_pitch_pulse,
  output logic [10:0]         out_left_wing_pulse,
  output logic [10:0]         out_right_wing_pulse,
  output logic                out_link_lost,
  output logic                out_busy
);
  import rcff_pkg::*;

  logic [8:0]  alpha_r, alpha_nxt;
  logic [15:0] timeout_r, timeout_nxt;
  logic [15:0] silence_r, silence_nxt;
  logic        lost_r, lost_nxt;
  held_arr_t   held_r, held_nxt;
  smooth_arr_t smooth_r, smooth_nxt;
  logic [10:0] target_r, target_nxt;
  logic [10:0] wing_left_r, wing_left_nxt;
  logic [10:0] wing_right_r, wing_right_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [10:0] out_thr_r, out_thr_nxt;
  logic [10:0] out_yaw_r, out_yaw_nxt;
  logic [10:0] out_pitch_r, out_pitch_nxt;
  logic [10:0] out_left_r, out_left_nxt;
  logic [10:0] out_right_r, out_right_nxt;
  logic        out_lost_r, out_lost_nxt;

  logic [2:0]         held_idx;
  logic [7:0]         map_in;
  logic [8:0]         alpha_eff;
  logic [10:0]        old_val;
  logic signed [11:0] diff;
  logic signed [21:0] prod;
  logic signed [21:0] acc;
  logic [10:0]        ema_val;
  logic [15:0]        silence_inc;
  logic               fail;
  logic [10:0]        left_sel, right_sel;

  // both roll channels read the roll byte, hold reads its own byte
  always_comb begin
    case (cmd.ch)
      CH_ROLL_RIGHT: held_idx = H_ROLL;
      CH_HOLD:       held_idx = H_HOLD;
      default:       held_idx = cmd.ch;
    endcase
  end

  assign map_in = (cmd.ch == CH_ROLL_RIGHT) ? ~held_r[held_idx] : held_r[held_idx];

  // a*t + (256-a)*o == 256*o + a*(t-o)
  assign alpha_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign old_val   = smooth_r[cmd.ch];
  assign diff      = $signed({1'b0, target_r}) - $signed({1'b0, old_val});
  assign prod      = $signed({1'b0, alpha_eff}) * diff;
  assign acc       = $signed({3'b000, old_val, 8'd0}) + prod;
  assign ema_val   = acc[18:8];

  assign silence_inc = (silence_r == SILENCE_MAX) ? silence_r : silence_r + 16'd1;
  assign fail        = silence_inc > timeout_r;

  always_comb begin
    if (held_r[H_SEL] == SEL_ROLL) begin
      left_sel  = smooth_r[CH_ROLL_LEFT];
      right_sel = smooth_r[CH_ROLL_RIGHT];
    end else if (held_r[H_SEL] == SEL_HOLD) begin
      left_sel  = smooth_r[CH_HOLD];
      right_sel = smooth_r[CH_HOLD];
    end else begin
      left_sel  = wing_left_r;
      right_sel = wing_right_r;
    end
  end

  always_comb begin
    alpha_nxt   = alpha_r;
    timeout_nxt = timeout_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ALPHA:   alpha_nxt   = cfg_data[8:0];
        CFG_TIMEOUT: timeout_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    held_nxt    = held_r;
    silence_nxt = silence_r;
    lost_nxt    = lost_r;
    if (cmd.take_packet) begin
      held_nxt    = '{in_throttle, in_yaw, in_pitch, in_roll, in_hold_level, in_aux_select};
      silence_nxt = '0;
    end else if (cmd.take_tick) begin
      silence_nxt = silence_inc;
      lost_nxt    = fail;
      if (fail) begin
        held_nxt = HELD_FAILSAFE;
      end
    end
  end

  always_comb begin
    target_nxt = target_r;
    smooth_nxt = smooth_r;
    if (cmd.map_en) begin
      target_nxt = map_pulse(map_in);
    end
    if (cmd.ema_en) begin
      smooth_nxt[cmd.ch] = ema_val;
    end
  end

  always_comb begin
    wing_left_nxt  = wing_left_r;
    wing_right_nxt = wing_right_r;
    out_thr_nxt    = out_thr_r;
    out_yaw_nxt    = out_yaw_r;
    out_pitch_nxt  = out_pitch_r;
    out_left_nxt   = out_left_r;
    out_right_nxt  = out_right_r;
    out_lost_nxt   = out_lost_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    if (cmd.finish) begin
      wing_left_nxt  = left_sel;
      wing_right_nxt = right_sel;
      out_thr_nxt    = smooth_r[CH_THROTTLE];
      out_yaw_nxt    = smooth_r[CH_YAW];
      out_pitch_nxt  = smooth_r[CH_PITCH];
      out_left_nxt   = left_sel;
      out_right_nxt  = right_sel;
      out_lost_nxt   = lost_r;
      out_valid_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r      <= ALPHA_RESET;
      timeout_r    <= TIMEOUT_RESET;
      silence_r    <= '0;
      lost_r       <= 1'b0;
      held_r       <= HELD_FAILSAFE;
      smooth_r     <= SMOOTH_RESET;
      wing_left_r  <= PULSE_MID;
      wing_right_r <= PULSE_MID;
      out_valid_r  <= 1'b0;
    end else begin
      alpha_r      <= alpha_nxt;
      timeout_r    <= timeout_nxt;
      silence_r    <= silence_nxt;
      lost_r       <= lost_nxt;
      held_r       <= held_nxt;
      smooth_r     <= smooth_nxt;
      wing_left_r  <= wing_left_nxt;
      wing_right_r <= wing_right_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    target_r    <= target_nxt;
    out_thr_r   <= out_thr_nxt;
    out_yaw_r   <= out_yaw_nxt;
    out_pitch_r <= out_pitch_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
    out_lost_r  <= out_lost_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_busy             = out_valid_r;
  assign out_throttle_pulse   = out_thr_r;
  assign out_yaw_pulse        = out_yaw_r;
  assign out_pitch_pulse      = out_pitch_r;
  assign out_left_wing_pulse  = out_left_r;
  assign out_right_wing_pulse = out_right_r;
  assign out_link_lost        = out_lost_r;

`ifndef NO_ASSERTIONS
  ap_target_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ema_en |-> (target_r >= PULSE_MIN && target_r <= PULSE_MAX))
    else $error("mapped target out of pulse range");

  ap_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_thr_r >= PULSE_MIN && out_thr_r <= PULSE_MAX))
    else $error("smoothed throttle out of pulse range");
`endif
endmodule

// ===== sv/rc_channel_filter_failsafe_top.sv =====
`timescale 1ns / 1ps
// Sequence: a tick transfer steps each of the six channels through a map state and
//   a smoothing state in one shared map/smoothing unit, then a done state loads the
//   output register once it is free (out_ready may stall it); a packet transfer is
//   absorbed in the accepting cycle and yields no result. Transfers are taken only while idle.
// Reset: synchronous, active-low rst_n; restores register defaults, failsafe bytes
//   and the initial smoothed and wing pulse values.
module rc_channel_filter_failsafe_top (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_throttle,
  input  logic [7:0]  in_yaw,
  input  logic [7:0]  in_pitch,
  input  logic [7:0]  in_roll,
  input  logic [7:0]  in_hold_level,
  input  logic [7:0]  in_aux_select,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] out_throttle_pulse,
  output logic [10:0] out_yaw_pulse,
  output logic [10:0] out_pitch_pulse,
  output logic [10:0] out_left_wing_pulse,
  output logic [10:0] out_right_wing_pulse,
  output logic        out_link_lost,
  // config writes: index 0 alpha (Q8), index 1 timeout in ticks
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rcff_pkg::*;

  rcff_cmd_t cmd;
  logic      out_busy;

  // The controller owns sequencing: it takes packet transfers while idle, and on a
  // tick walks channels 0..5 through a map step (byte -> 1000..2000 us via a
  // reciprocal multiply) and a smoothing step (one alpha multiply), then loads the
  // output register once it is free. Packets are still taken while a loaded result waits in the output register.
  rcff_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .out_ready   (out_ready),
    .out_busy    (out_busy),
    .in_ready    (in_ready),
    .cmd         (cmd)
  );

  // The datapath holds the received bytes, silence counter, smoothed values, last
  // wing pulses, config registers and the output register.
  rcff_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_throttle          (in_throttle),
    .in_yaw               (in_yaw),
    .in_pitch             (in_pitch),
    .in_roll              (in_roll),
    .in_hold_level        (in_hold_level),
    .in_aux_select        (in_aux_select),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .out_throttle_pulse   (out_throttle_pulse),
    .out_yaw_pulse        (out_yaw_pulse),
    .out_pitch_pulse      (out_pitch_pulse),
    .out_left_wing_pulse  (out_left_wing_pulse),
    .out_right_wing_pulse (out_right_wing_pulse),
    .out_link_lost        (out_link_lost),
    .out_busy             (out_busy)
  );

endmodule

// ===== tb/rc_channel_filter_failsafe_top_tb.sv =====
`timescale 1ns / 1ps
module rc_channel_filter_failsafe_top_tb;
  import rcff_pkg::*;

  // settle time after the last result before a register write or the verdict;
  // a tick runs a map and a smoothing step per channel, a packet is absorbed at once
  localparam int SETTLE_CYCLES   = 24;
  // cycles with no transfer on either channel before the run is called hung
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 300;

  // register indexes past the two real ones; writes there must do nothing
  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic       req;
    logic [7:0] throttle;
    logic [7:0] yaw;
    logic [7:0] pitch;
    logic [7:0] roll;
    logic [7:0] hold;
    logic [7:0] sel;
  } rc_item_t;

  typedef struct packed {
    logic [10:0] throttle;
    logic [10:0] yaw;
    logic [10:0] pitch;
    logic [10:0] left_wing;
    logic [10:0] right_wing;
    logic        link_lost;
  } pulse_set_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = REQ_PACKET;
  logic [7:0]  in_throttle = 8'd0;
  logic [7:0]  in_yaw = 8'd0;
  logic [7:0]  in_pitch = 8'd0;
  logic [7:0]  in_roll = 8'd0;
  logic [7:0]  in_hold_level = 8'd0;
  logic [7:0]  in_aux_select = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [10:0] out_throttle_pulse;
  logic [10:0] out_yaw_pulse;
  logic [10:0] out_pitch_pulse;
  logic [10:0] out_left_wing_pulse;
  logic [10:0] out_right_wing_pulse;
  logic        out_link_lost;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_ALPHA;
  logic [15:0] cfg_data = 16'd0;

  rc_channel_filter_failsafe_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_throttle         (in_throttle),
    .in_yaw              (in_yaw),
    .in_pitch            (in_pitch),
    .in_roll             (in_roll),
    .in_hold_level       (in_hold_level),
    .in_aux_select       (in_aux_select),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_throttle_pulse  (out_throttle_pulse),
    .out_yaw_pulse       (out_yaw_pulse),
    .out_pitch_pulse     (out_pitch_pulse),
    .out_left_wing_pulse (out_left_wing_pulse),
    .out_right_wing_pulse(out_right_wing_pulse),
    .out_link_lost       (out_link_lost),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Filter mirror: held bytes, silence counter, smoothed pulses, wing memory and
  // the two registers, stepped once per accepted transfer.
  // ---------------------------------------------------------------------------
  held_arr_t   held_byte;
  smooth_arr_t smooth_pulse;
  logic [10:0] wing_memory [2];
  logic [15:0] silent_ticks;
  logic [8:0]  alpha_w;
  logic [15:0] timeout_w;

  pulse_set_t  expected_pulses [$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  bit          gaps_on = 1'b0;   // random idle bursts on both channels

  function automatic logic [10:0] byte_to_pulse(input logic [7:0] x, input bit invert);
    int unsigned v;
    v = invert ? 255 - x : x;
    v = PULSE_MIN + (v * 1000) / 255;
    return v[10:0];
  endfunction

  // one EMA step, weight a in 256ths on the new sample
  function automatic logic [10:0] ema_step(input logic [10:0] target, input logic [10:0] prev,
                                           input logic [8:0] a);
    int unsigned acc;
    int unsigned wa;
    wa  = a;
    acc = wa * target + (256 - wa) * prev;
    acc = acc >> 8;
    return acc[10:0];
  endfunction

  function automatic void reset_filter_mirror();
    held_byte      = HELD_FAILSAFE;
    smooth_pulse   = SMOOTH_RESET;
    wing_memory[0] = PULSE_MID;
    wing_memory[1] = PULSE_MID;
    silent_ticks   = 16'd0;
    alpha_w        = ALPHA_RESET;
    timeout_w      = TIMEOUT_RESET;
  endfunction

  // Packets just latch bytes and clear silence; ticks produce one pulse set.
  function automatic void track_item(input rc_item_t it);
    smooth_arr_t target;
    logic [8:0]  a;
    pulse_set_t  ps;
    if (it.req == REQ_PACKET) begin
      held_byte[CH_THROTTLE] = it.throttle;
      held_byte[CH_YAW]      = it.yaw;
      held_byte[CH_PITCH]    = it.pitch;
      held_byte[H_ROLL]      = it.roll;
      held_byte[H_HOLD]      = it.hold;
      held_byte[H_SEL]       = it.sel;
      silent_ticks           = 16'd0;
      return;
    end
    if (silent_ticks != SILENCE_MAX)
      silent_ticks++;
    ps.link_lost = silent_ticks > timeout_w;
    if (ps.link_lost)
      held_byte = HELD_FAILSAFE;
    target[CH_THROTTLE]   = byte_to_pulse(held_byte[CH_THROTTLE], 1'b0);
    target[CH_YAW]        = byte_to_pulse(held_byte[CH_YAW], 1'b0);
    target[CH_PITCH]      = byte_to_pulse(held_byte[CH_PITCH], 1'b0);
    target[CH_ROLL_LEFT]  = byte_to_pulse(held_byte[H_ROLL], 1'b0);
    target[CH_ROLL_RIGHT] = byte_to_pulse(held_byte[H_ROLL], 1'b1);
    target[CH_HOLD]       = byte_to_pulse(held_byte[H_HOLD], 1'b0);
    // weights past one are clamped to one
    a = (alpha_w > ALPHA_ONE) ? ALPHA_ONE : alpha_w;
    for (int i = 0; i < NUM_SMOOTH; i++)
      smooth_pulse[i] = ema_step(target[i], smooth_pulse[i], a);
    case (held_byte[H_SEL])
      SEL_ROLL: begin
        wing_memory[0] = smooth_pulse[CH_ROLL_LEFT];
        wing_memory[1] = smooth_pulse[CH_ROLL_RIGHT];
      end
      SEL_HOLD: begin
        wing_memory[0] = smooth_pulse[CH_HOLD];
        wing_memory[1] = smooth_pulse[CH_HOLD];
      end
      default: ;   // keep mode: wings repeat what they showed last
    endcase
    ps.throttle   = smooth_pulse[CH_THROTTLE];
    ps.yaw        = smooth_pulse[CH_YAW];
    ps.pitch      = smooth_pulse[CH_PITCH];
    ps.left_wing  = wing_memory[0];
    ps.right_wing = wing_memory[1];
    expected_pulses.push_back(ps);
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------
  function automatic rc_item_t make_packet(input logic [7:0] th, input logic [7:0] yw,
                                           input logic [7:0] pt, input logic [7:0] rl,
                                           input logic [7:0] hd, input logic [7:0] sl);
    rc_item_t it;
    it = '{req: REQ_PACKET, throttle: th, yaw: yw, pitch: pt, roll: rl, hold: hd, sel: sl};
    return it;
  endfunction

  // bytes skewed toward the ends of the range
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic rc_item_t random_packet();
    logic [7:0] sl;
    int         pick;
    pick = $urandom_range(0, 9);
    if (pick inside {[0:3]})
      sl = SEL_ROLL;
    else if (pick inside {[4:6]})
      sl = SEL_HOLD;
    else
      sl = 8'($urandom_range(0, 255));
    return make_packet(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(), sl);
  endfunction

  // tick with junk in the byte fields; the block must ignore them
  function automatic rc_item_t junk_tick();
    rc_item_t it;
    it     = random_packet();
    it.req = REQ_TICK;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: inputs move on the falling edge, transfers are seen at the rising edge
  // ---------------------------------------------------------------------------
  task automatic send_item(input rc_item_t it);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 12);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      = 1'b1;
    in_req_type   = it.req;
    in_throttle   = it.throttle;
    in_yaw        = it.yaw;
    in_pitch      = it.pitch;
    in_roll       = it.roll;
    in_hold_level = it.hold;
    in_aux_select = it.sel;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_item(it);
  endtask

  // let every outstanding tick come back, then give the pipe time to empty
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_pulses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_ALPHA:   alpha_w = val[8:0];
      CFG_TIMEOUT: timeout_w = val;
      default: ;
    endcase
  endtask

  // result side: random stall bursts on out_ready while gaps are enabled
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else if (gaps_on && $urandom_range(0, 3) == 0) begin
      out_ready  = 1'b0;
      stall_left = $urandom_range(0, 11);
    end else begin
      out_ready = 1'b1;
    end
  end

  task automatic check_field(input string what, input logic [10:0] got,
                             input logic [10:0] want);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    pulse_set_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pulses.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected transfer, expected none actual %0d %0d %0d %0d %0d %0b",
                 $time, out_throttle_pulse, out_yaw_pulse, out_pitch_pulse,
                 out_left_wing_pulse, out_right_wing_pulse, out_link_lost);
      end else begin
        want = expected_pulses.pop_front();
        check_field("throttle_pulse", out_throttle_pulse, want.throttle);
        check_field("yaw_pulse", out_yaw_pulse, want.yaw);
        check_field("pitch_pulse", out_pitch_pulse, want.pitch);
        check_field("left_wing_pulse", out_left_wing_pulse, want.left_wing);
        check_field("right_wing_pulse", out_right_wing_pulse, want.right_wing);
        check_field("link_lost", 11'(out_link_lost), 11'(want.link_lost));
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, expected_pulses.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // no packet yet: failsafe bytes, reset smoothing and mid wings, roll mix mode
  task automatic test_reset_state();
    repeat (2) send_item(junk_tick());
  endtask

  // all-zero and all-one on every byte, then alternating bit patterns in hold mode
  task automatic test_field_extremes();
    send_item(make_packet(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(junk_tick());
    send_item(make_packet(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    send_item(junk_tick());
    send_item(make_packet(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h01));
    send_item(junk_tick());
  endtask

  // roll mode, then a keep mode that must freeze the wings
  task automatic test_wing_modes();
    send_item(make_packet(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, SEL_ROLL));
    send_item(junk_tick());
    send_item(make_packet(8'd10, 8'd20, 8'd30, 8'd40, 8'd200, 8'd2));
    send_item(junk_tick());
  endtask

  // weight zero (frozen), one (no smoothing), and above one (clamped)
  task automatic test_alpha_settings();
    logic [8:0] alphas [4];
    alphas = '{9'd0, ALPHA_ONE, 9'd300, 9'h1FF};
    foreach (alphas[i]) begin
      drain_results();
      write_reg(CFG_ALPHA, 16'(alphas[i]));
      send_item(junk_tick());
    end
  endtask

  // timeout zero trips on every tick; a short timeout trips after a few silent ticks;
  // writes past the last register must be ignored
  task automatic test_timeout_edges();
    drain_results();
    write_reg(CFG_ALPHA, 16'(ALPHA_RESET));
    write_reg(CFG_TIMEOUT, 16'd0);
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'h0001);
    send_item(junk_tick());
    drain_results();
    write_reg(CFG_TIMEOUT, 16'd2);
    send_item(make_packet(8'd200, 8'd1, 8'd254, 8'd128, 8'd127, SEL_HOLD));
    repeat (3) send_item(junk_tick());
  endtask

  // a timeout at the counter's top value never trips
  task automatic test_timeout_ceiling();
    drain_results();
    gaps_on = 1'b0;
    write_reg(CFG_TIMEOUT, SILENCE_MAX);
    send_item(random_packet());
    repeat (3) send_item(junk_tick());
  endtask

  // Phases of mostly packet-then-ticks traffic under varied register settings.
  // Short timeouts keep failsafe entry and recovery frequent. Last phase runs flat out.
  task automatic test_random_traffic();
    int sent;
    int burst;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      gaps_on = (phase % 2 == 0) && (phase != RANDOM_PHASES - 1);
      case ($urandom_range(0, 5))
        0:       write_reg(CFG_ALPHA, 16'd0);
        1:       write_reg(CFG_ALPHA, 16'(ALPHA_ONE));
        2:       write_reg(CFG_ALPHA, 16'(ALPHA_RESET));
        3:       write_reg(CFG_ALPHA, 16'($urandom_range(257, 511)));
        default: write_reg(CFG_ALPHA, 16'($urandom_range(1, 255)));
      endcase
      case ($urandom_range(0, 5))
        0:       write_reg(CFG_TIMEOUT, 16'd0);
        1:       write_reg(CFG_TIMEOUT, 16'($urandom_range(40, 65535)));
        default: write_reg(CFG_TIMEOUT, 16'($urandom_range(1, 30)));
      endcase
      if ($urandom_range(0, 1) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                  16'($urandom_range(0, 65535)));
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        // mostly a packet followed by a run of ticks; sometimes ticks alone or
        // back-to-back packets
        if ($urandom_range(0, 5) != 0) begin
          send_item(random_packet());
          sent++;
        end
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
        repeat (burst) send_item(junk_tick());
        sent += burst;
      end
    end
  endtask

  initial begin
    reset_filter_mirror();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_field_extremes();
    test_wing_modes();
    test_alpha_settings();
    test_timeout_edges();
    test_timeout_ceiling();
    test_random_traffic();

    drain_results();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
